>>> rtl/core/fcm_pkg.sv
// Shared constants, request and status codes, and types of the chain manager.
package fcm_pkg;

   // table geometry (fixed by the field widths)
   localparam int BLOCKS           = 1024;
   localparam int FIRST_DATA_BLOCK = 5;
   localparam int BLOCK_BYTES      = 1024;

   localparam int IDX_W  = 10;  // block index
   localparam int ENT_W  = 11;  // table entry: link, end or free code
   localparam int POS_W  = 20;  // byte position within a file
   localparam int OFF_W  = 10;  // byte offset within a block
   localparam int STEP_W = POS_W - OFF_W;
   localparam int REQ_W  = 3;
   localparam int STAT_W = 2;

   localparam logic [ENT_W-1:0] END_CODE  = ENT_W'(BLOCKS);
   localparam logic [ENT_W-1:0] FREE_CODE = ENT_W'(BLOCKS + 1);
   localparam logic [IDX_W-1:0] LAST_BLK  = IDX_W'(BLOCKS - 1);
   localparam logic [IDX_W-1:0] FIRST_BLK = IDX_W'(FIRST_DATA_BLOCK);

   // request codes
   localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_FREE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_EXTEND = 3'd2;
   localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
   localparam logic [STAT_W-1:0] ST_BROKEN  = 2'd2;

   // table write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [ENT_W-1:0] data;
   } tbl_wr_type;

endpackage

>>> rtl/core/fcm_req_if.sv
// Request channel: valid/ready handshake with the request payload.
interface fcm_req_if;
   import fcm_pkg::*;

   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic [IDX_W-1:0] block_index;
   logic [POS_W-1:0] byte_position;
   logic [ENT_W-1:0] entry_value;

   modport source (output valid, req_type, block_index, byte_position, entry_value,
                   input ready);
   modport sink   (input valid, req_type, block_index, byte_position, entry_value,
                   output ready);
endinterface

>>> rtl/core/fcm_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
interface fcm_rsp_if;
   import fcm_pkg::*;

   logic              valid;
   logic              ready;
   logic [ENT_W-1:0]  result_block;
   logic [OFF_W-1:0]  byte_in_block;
   logic [STAT_W-1:0] status;

   modport source (output valid, result_block, byte_in_block, status, input ready);
   modport sink   (input valid, result_block, byte_in_block, status, output ready);
endinterface

>>> rtl/core/fcm_link_table.sv
// Link table memory: one write port, one registered read port, write forwarding.
module fcm_link_table (
   input  logic                    clock,
   input  logic                    reset,
   input  fcm_pkg::tbl_wr_type     wr,
   input  logic [fcm_pkg::IDX_W-1:0] rd_addr,
   output logic [fcm_pkg::ENT_W-1:0] rd_data
);
   import fcm_pkg::*;

   logic [ENT_W-1:0] mem [BLOCKS];
   logic [ENT_W-1:0] rd_raw_ff;
   logic             byp_ff;
   logic [ENT_W-1:0] byp_data_ff;

   // write and registered read; the read sees the old contents
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_raw_ff   <= mem[rd_addr];
      byp_data_ff <= wr.data;
   end

   // note a read that collides with the write of the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= wr.en && (wr.addr == rd_addr);
      end
   end

   // forward the newer value on a collision
   assign rd_data = byp_ff ? byp_data_ff : rd_raw_ff;

endmodule

>>> rtl/core/fat_chain_manager_core.sv
// Top level of the file allocation table chain manager.
// After reset the block sweeps the link table into the formatted image, one entry a cycle,
// through all 1024 entries, and takes no request until that is done. Requests are then
// handled one at a time, every step going through the one table (one read and one write
// per cycle). Locate walks position / 1024 links, at most 1023. Free chain walks the chain
// and frees every block of it. Allocate scans the table entry by entry; the scan
// starts at a kept low-water mark below which no data block is free, so it usually ends at
// once. Extend that links a fresh block runs that scan and then a link step. A new request
// is taken while the previous result still waits in the output register.
module fat_chain_manager_core (
   input  logic      clock,
   input  logic      reset,
   fcm_req_if.sink   req_chan,
   fcm_rsp_if.source rsp_chan
);
   import fcm_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_LINK   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [ENT_W-1:0]  hint_ff, hint_in;
   logic [ENT_W-1:0]  chk_ff, chk_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [REQ_W-1:0]  op_ff, op_in;
   logic [ENT_W-1:0]  val_ff, val_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [ENT_W-1:0]  res_ff, res_in;
   logic [STAT_W-1:0] st_ff, st_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ENT_W-1:0]  rsp_block_ff;
   logic [OFF_W-1:0]  rsp_off_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic              rsp_load;

   tbl_wr_type        wr;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_data;
   logic [ENT_W-1:0]  chk_next;
   logic              rd_is_link;

   fcm_link_table u_table (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign chk_next   = chk_ff + ENT_W'(1);
   assign rd_is_link = (rd_data < END_CODE);
   assign rsp_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      hint_in  = hint_ff;
      chk_in   = chk_ff;
      cur_in   = cur_ff;
      steps_in = steps_ff;
      op_in    = op_ff;
      val_in   = val_ff;
      off_in   = off_ff;
      res_in   = res_ff;
      st_in    = st_ff;
      rd_addr  = cur_ff;
      wr       = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the formatted image into the table
            wr.en   = 1'b1;
            wr.addr = clr_ff;
            wr.data = (clr_ff <= FIRST_BLK) ? END_CODE : FREE_CODE;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_BLK) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            rd_addr = (req_chan.req_type == REQ_ALLOC) ? hint_ff[IDX_W-1:0]
                                                       : req_chan.block_index;
            if (req_chan.valid) begin
               op_in    = req_chan.req_type;
               cur_in   = req_chan.block_index;
               steps_in = req_chan.byte_position[POS_W-1:OFF_W];
               val_in   = req_chan.entry_value;
               off_in   = (req_chan.req_type == REQ_LOCATE)
                          ? req_chan.byte_position[OFF_W-1:0] : '0;
               res_in   = '0;
               st_in    = ST_OK;
               chk_in   = hint_ff;
               unique case (req_chan.req_type)
                  REQ_ALLOC: state_in = S_SCAN;
                  REQ_FREE, REQ_EXTEND, REQ_WRITE, REQ_READ: state_in = S_EXEC;
                  REQ_LOCATE: begin
                     if (req_chan.byte_position[POS_W-1:OFF_W] == '0) begin
                        res_in   = {1'b0, req_chan.block_index};
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_EXEC;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end

         S_EXEC: begin
            // rd_data holds the entry of cur_ff
            unique case (op_ff)
               REQ_FREE: begin
                  wr.en   = 1'b1;
                  wr.addr = cur_ff;
                  wr.data = FREE_CODE;
                  if (rd_data == END_CODE) begin
                     state_in = S_FINISH;
                  end else if (!rd_is_link) begin
                     st_in    = ST_BROKEN;
                     state_in = S_FINISH;
                  end else begin
                     cur_in  = rd_data[IDX_W-1:0];
                     rd_addr = rd_data[IDX_W-1:0];
                  end
               end
               REQ_EXTEND: begin
                  if (rd_data == END_CODE) begin
                     rd_addr  = hint_ff[IDX_W-1:0];
                     chk_in   = hint_ff;
                     state_in = S_SCAN;
                  end else begin
                     res_in   = rd_data;
                     st_in    = rd_is_link ? ST_OK : ST_BROKEN;
                     state_in = S_FINISH;
                  end
               end
               REQ_LOCATE: begin
                  res_in = rd_data;
                  if (!rd_is_link) begin
                     st_in    = ST_BROKEN;
                     state_in = S_FINISH;
                  end else if (steps_ff == STEP_W'(1)) begin
                     state_in = S_FINISH;
                  end else begin
                     cur_in   = rd_data[IDX_W-1:0];
                     rd_addr  = rd_data[IDX_W-1:0];
                     steps_in = steps_ff - STEP_W'(1);
                  end
               end
               REQ_WRITE: begin
                  // drop values above the free code, echo the entry
                  if (val_ff <= FREE_CODE) begin
                     wr.en   = 1'b1;
                     wr.addr = cur_ff;
                     wr.data = val_ff;
                     res_in  = val_ff;
                  end else begin
                     res_in = rd_data;
                  end
                  state_in = S_FINISH;
               end
               REQ_READ: begin
                  res_in   = rd_data;
                  state_in = S_FINISH;
               end
               default: state_in = S_FINISH;
            endcase
         end

         S_SCAN: begin
            // rd_data holds the entry of chk_ff
            if (chk_ff == END_CODE) begin
               res_in   = END_CODE;
               st_in    = ST_NO_FREE;
               hint_in  = END_CODE;
               state_in = S_FINISH;
            end else if (rd_data == FREE_CODE) begin
               wr.en    = 1'b1;
               wr.addr  = chk_ff[IDX_W-1:0];
               wr.data  = END_CODE;
               res_in   = chk_ff;
               hint_in  = chk_next;
               state_in = (op_ff == REQ_EXTEND) ? S_LINK : S_FINISH;
            end else begin
               chk_in  = chk_next;
               rd_addr = chk_next[IDX_W-1:0];
            end
         end

         S_LINK: begin
            // point the extended block at the fresh one
            wr.en    = 1'b1;
            wr.addr  = cur_ff;
            wr.data  = res_ff;
            state_in = S_FINISH;
         end

         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // lower the low-water mark when a data block becomes free
      if (state_ff != S_CLEAR && wr.en && wr.data == FREE_CODE &&
          wr.addr >= FIRST_BLK && {1'b0, wr.addr} < hint_ff) begin
         hint_in = {1'b0, wr.addr};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         hint_ff  <= {1'b0, FIRST_BLK};
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         hint_ff  <= hint_in;
      end
   end

   // request working registers
   always_ff @(posedge clock) begin
      chk_ff   <= chk_in;
      cur_ff   <= cur_in;
      steps_ff <= steps_in;
      op_ff    <= op_in;
      val_ff   <= val_in;
      off_ff   <= off_in;
      res_ff   <= res_in;
      st_ff    <= st_in;
   end

   // output register: load on finish, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_block_ff  <= res_ff;
         rsp_off_ff    <= off_ff;
         rsp_status_ff <= st_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.result_block  = rsp_block_ff;
   assign rsp_chan.byte_in_block = rsp_off_ff;
   assign rsp_chan.status        = rsp_status_ff;

   // a fresh block is linked only right after the scan that found it
   a_link_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LINK) |-> ($past(state_ff) == S_SCAN))
      else $error("link step without a preceding scan");

   // the allocation scan never claims a reserved block
   a_scan_data_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && wr.en) |-> (wr.addr >= FIRST_BLK && wr.data == END_CODE))
      else $error("scan wrote a reserved block or a non-end code");

   // the low-water mark stays within the data area
   a_hint_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |-> (hint_ff >= {1'b0, FIRST_BLK} && hint_ff <= END_CODE))
      else $error("free-block mark out of range");

   // a result appears only when a request finishes
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |-> (state_ff == S_FINISH))
      else $error("response raised outside finish");

endmodule

>>> sim/tb.sv
// Testbench of the chain manager: queued requests, clocked driver and monitor, table predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fcm_pkg::*;

   localparam int PLAN_COPY = 0;  // table copy that steers the stimulus
   localparam int LIVE_COPY = 1;  // table copy advanced at each request transfer

   // request codes the block does not define
   localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

   localparam int     RANDOM_ITEMS = 600;
   localparam int     GROW_BLOCKS  = 200;
   localparam int     MAX_FILES    = 12;
   localparam int     MAX_FILE_LEN = 24;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     SHOWN_FAULTS = 10;
   localparam longint RUN_LIMIT_NS = 200_000_000;

   typedef struct packed {
      logic [REQ_W-1:0] kind;
      logic [IDX_W-1:0] blk;
      logic [POS_W-1:0] pos;
      logic [ENT_W-1:0] val;
   } fat_request_type;

   typedef struct packed {
      logic [ENT_W-1:0]  blk;
      logic [OFF_W-1:0]  off;
      logic [STAT_W-1:0] st;
   } fat_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid    = 1'b0;
   logic [REQ_W-1:0]  req_type     = '0;
   logic [IDX_W-1:0]  req_block    = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic [ENT_W-1:0]  req_entry    = '0;
   logic              rsp_ready    = 1'b0;
   logic              rsp_hold     = 1'b0;

   fcm_req_if req_if ();
   fcm_rsp_if rsp_if ();

   assign req_if.valid         = req_valid;
   assign req_if.req_type      = req_type;
   assign req_if.block_index   = req_block;
   assign req_if.byte_position = req_position;
   assign req_if.entry_value   = req_entry;
   assign rsp_if.ready         = rsp_ready;

   fat_chain_manager_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // two copies of the link table: one for planning, one for checking
   logic [ENT_W-1:0] link_copy [2][BLOCKS];

   fat_request_type pending_req [$];
   fat_result_type  expected_rsp [$];

   int planned_total = 0;
   int req_issued    = 0;
   int req_taken     = 0;
   int req_gap       = 0;
   int rsp_taken     = 0;
   int rsp_seen      = 0;
   int rsp_wait      = 0;
   int fault_count   = 0;
   int calm_left [2] = '{0, 0};
   int kind_count [8] = '{default: 0};
   int stat_count [4] = '{default: 0};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // load the formatted image: reserved and root blocks end, the rest free
   function automatic void format_table(input int side);
      for (int i = 0; i < BLOCKS; i++)
         link_copy[side][i] = (i <= FIRST_DATA_BLOCK) ? END_CODE : FREE_CODE;
   endfunction

   function automatic logic [ENT_W-1:0] first_free(input int side);
      for (int i = FIRST_DATA_BLOCK; i < BLOCKS; i++)
         if (link_copy[side][i] == FREE_CODE)
            return ENT_W'(i);
      return END_CODE;
   endfunction

   // apply one request to a table copy and return the result it gives
   function automatic fat_result_type serve_request(input int side, input fat_request_type r);
      fat_result_type    o;
      logic [ENT_W-1:0]  e;
      logic [ENT_W-1:0]  cur;
      logic [ENT_W-1:0]  fr;
      logic [STEP_W-1:0] steps;
      o = '0;
      case (r.kind)
         REQ_ALLOC: begin
            fr = first_free(side);
            if (fr < END_CODE) begin
               link_copy[side][fr[IDX_W-1:0]] = END_CODE;
               o.blk = fr;
            end else begin
               o.blk = END_CODE;
               o.st  = ST_NO_FREE;
            end
         end
         REQ_FREE: begin
            // walk and clear; a free code ends the walk as broken, loops included
            cur  = {1'b0, r.blk};
            o.st = ST_BROKEN;
            for (int n = 0; n < BLOCKS; n++) begin
               e = link_copy[side][cur[IDX_W-1:0]];
               link_copy[side][cur[IDX_W-1:0]] = FREE_CODE;
               if (e == END_CODE) begin
                  o.st = ST_OK;
                  break;
               end
               if (e >= END_CODE)
                  break;
               cur = e;
            end
         end
         REQ_EXTEND: begin
            e = link_copy[side][r.blk];
            if (e == END_CODE) begin
               fr = first_free(side);
               if (fr < END_CODE) begin
                  link_copy[side][r.blk] = fr;
                  link_copy[side][fr[IDX_W-1:0]] = END_CODE;
                  o.blk = fr;
               end else begin
                  o.blk = END_CODE;
                  o.st  = ST_NO_FREE;
               end
            end else begin
               o.blk = e;
               if (e >= END_CODE)
                  o.st = ST_BROKEN;
            end
         end
         REQ_LOCATE: begin
            steps = r.pos[POS_W-1:OFF_W];
            o.off = r.pos[OFF_W-1:0];
            cur   = {1'b0, r.blk};
            while (steps != '0) begin
               steps = steps - 1'b1;
               cur   = link_copy[side][cur[IDX_W-1:0]];
               if (cur >= END_CODE) begin
                  o.st = ST_BROKEN;
                  break;
               end
            end
            o.blk = cur;
         end
         REQ_WRITE: begin
            if (r.val <= FREE_CODE)
               link_copy[side][r.blk] = r.val;
            o.blk = link_copy[side][r.blk];
         end
         REQ_READ:
            o.blk = link_copy[side][r.blk];
         default:
            o = '0;
      endcase
      return o;
   endfunction

   // idle cycles before the next transfer, with calm stretches of none
   function automatic int pick_gap(input int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left[side] = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   // queue a request and step the planning table with it
   task automatic plan_request(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] blk,
                               input logic [POS_W-1:0] pos, input logic [ENT_W-1:0] val,
                               output fat_result_type o);
      fat_request_type r;
      r.kind = kind;
      r.blk  = blk;
      r.pos  = pos;
      r.val  = val;
      o = serve_request(PLAN_COPY, r);
      pending_req.push_back(r);
      planned_total++;
   endtask

   // offer queued requests, each after its own random gap
   always @(negedge clock) begin : drive_req
      fat_request_type offer;
      if (!reset && req_issued == req_taken) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_req.size() > 0) begin
            offer = pending_req.pop_front();
            req_type     <= offer.kind;
            req_block    <= offer.blk;
            req_position <= offer.pos;
            req_entry    <= offer.val;
            req_valid    <= 1'b1;
            req_issued++;
            req_gap = pick_gap(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall the result channel after each transfer, and during the long hold
   always @(negedge clock) begin
      if (rsp_seen != rsp_taken) begin
         rsp_seen = rsp_taken;
         rsp_wait = pick_gap(1);
      end
      if (rsp_hold || rsp_wait > 0) begin
         rsp_ready <= 1'b0;
         if (!rsp_hold)
            rsp_wait--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // hold the result channel off for a long stretch while requests keep coming
   initial begin : hold_off
      int stretch;
      for (stretch = 0; stretch < 2; stretch++) begin
         while (req_taken < ((stretch == 0) ? 300 : 700))
            @(negedge clock);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // predict on each request transfer, check each result transfer
   always @(posedge clock) begin : watch
      fat_request_type taken;
      fat_result_type  want;
      if (!reset && req_valid && req_if.ready) begin
         taken.kind = req_type;
         taken.blk  = req_block;
         taken.pos  = req_position;
         taken.val  = req_entry;
         expected_rsp.push_back(serve_request(LIVE_COPY, taken));
         kind_count[req_type]++;
         req_taken++;
      end
      if (!reset && rsp_if.valid && rsp_ready) begin
         rsp_taken++;
         stat_count[rsp_if.status]++;
         if (expected_rsp.size() == 0) begin
            fault_count++;
            if (fault_count <= SHOWN_FAULTS)
               $display("%0t: result with nothing pending: block %0d offset %0d status %0d",
                        $realtime, rsp_if.result_block, rsp_if.byte_in_block, rsp_if.status);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_if.result_block !== want.blk || rsp_if.byte_in_block !== want.off ||
                rsp_if.status !== want.st) begin
               fault_count++;
               if (fault_count <= SHOWN_FAULTS)
                  $display("%0t: result %0d expected block %0d offset %0d status %0d, got %0d %0d %0d",
                           $realtime, rsp_taken, want.blk, want.off, want.st,
                           rsp_if.result_block, rsp_if.byte_in_block, rsp_if.status);
            end
         end
      end
   end

   initial begin : stimulus
      fat_result_type   got;
      int               made, op, k, steps;
      logic [IDX_W-1:0] head, tail;
      logic [POS_W-1:0] pos;

      format_table(PLAN_COPY);
      format_table(LIVE_COPY);

      // directed: field extremes, every request code, chain corner cases
      plan_request(REQ_READ,   10'd0,    '0,          '0,         got);
      plan_request(REQ_READ,   10'd1023, '1,          '1,         got);
      plan_request(REQ_ALLOC,  '1,       '1,          '1,         got);
      plan_request(REQ_EXTEND, 10'd6,    '0,          '0,         got);  // end: link a fresh block
      plan_request(REQ_EXTEND, 10'd6,    '0,          '0,         got);  // link: returned as is
      plan_request(REQ_EXTEND, 10'd1000, '0,          '0,         got);  // free entry
      plan_request(REQ_LOCATE, 10'd6,    20'd0,       '0,         got);
      plan_request(REQ_LOCATE, 10'd6,    20'd1041,    '0,         got);
      plan_request(REQ_LOCATE, 10'd6,    20'd3071,    '0,         got);  // runs off the end
      plan_request(REQ_LOCATE, 10'd1000, 20'd1024,    '0,         got);  // meets a free code
      plan_request(REQ_WRITE,  10'd8,    '0,          11'd8,      got);  // self loop
      plan_request(REQ_LOCATE, 10'd8,    20'hFFFFF,   '0,         got);  // longest walk
      plan_request(REQ_FREE,   10'd8,    '0,          '0,         got);  // loop ends as broken
      plan_request(REQ_WRITE,  10'd9,    '0,          11'h7FF,    got);  // above free code
      plan_request(REQ_WRITE,  10'd9,    '0,          END_CODE,   got);
      plan_request(REQ_WRITE,  10'd10,   '0,          11'd0,      got);
      plan_request(REQ_READ,   10'd10,   '0,          '0,         got);
      plan_request(REQ_FREE,   10'd6,    '0,          '0,         got);
      plan_request(REQ_FREE,   10'd0,    '0,          '0,         got);  // reserved block
      plan_request(REQ_ALLOC,  '0,       '0,          '0,         got);
      plan_request(REQ_WRITE,  10'd0,    '0,          END_CODE,   got);
      plan_request(REQ_WRITE,  10'd1023, '1,          11'd1023,   got);
      plan_request(REQ_SPARE_A, '1,      '1,          '1,         got);
      plan_request(REQ_SPARE_B, '1,      '1,          '1,         got);
      plan_request(REQ_FREE,   10'd9,    '0,          '0,         got);

      // random: mostly file life cycles, some raw access and broken requests
      begin : random_files
         int file_head [$];
         int file_tail [$];
         int file_len  [$];
         made = 0;
         while (made < RANDOM_ITEMS) begin
            op = $urandom_range(0, 99);
            if (file_head.size() == 0)
               op = 0;
            else if (file_head.size() >= MAX_FILES && op < 40)
               op = 70;
            if (op >= 15 && op < 40) begin
               k = $urandom_range(0, file_head.size() - 1);
               if (file_len[k] >= MAX_FILE_LEN)
                  op = 50;
            end else if (file_head.size() > 0) begin
               k = $urandom_range(0, file_head.size() - 1);
            end
            if (op < 15) begin
               plan_request(REQ_ALLOC, IDX_W'($urandom), POS_W'($urandom),
                            ENT_W'($urandom), got);
               if (got.st == ST_OK) begin
                  file_head.push_back(int'(got.blk));
                  file_tail.push_back(int'(got.blk));
                  file_len.push_back(1);
               end
            end else if (op < 40) begin
               plan_request(REQ_EXTEND, IDX_W'(file_tail[k]), POS_W'($urandom),
                            ENT_W'($urandom), got);
               if (got.st == ST_OK) begin
                  file_tail[k] = int'(got.blk);
                  file_len[k]++;
               end
            end else if (op < 65) begin
               steps = $urandom_range(0, file_len[k] + 1);
               pos   = {STEP_W'(steps), OFF_W'($urandom_range(0, BLOCK_BYTES - 1))};
               if ($urandom_range(0, 15) == 0)
                  pos = POS_W'($urandom);
               plan_request(REQ_LOCATE, IDX_W'(file_head[k]), pos, ENT_W'($urandom), got);
            end else if (op < 75) begin
               plan_request(REQ_FREE, IDX_W'(file_head[k]), POS_W'($urandom),
                            ENT_W'($urandom), got);
               file_head.delete(k);
               file_tail.delete(k);
               file_len.delete(k);
            end else if (op < 85) begin
               plan_request(REQ_READ, IDX_W'($urandom), POS_W'($urandom),
                            ENT_W'($urandom), got);
            end else if (op < 91) begin
               plan_request(REQ_WRITE, IDX_W'($urandom), POS_W'($urandom),
                            ENT_W'($urandom_range(0, 2047)), got);
            end else if (op < 97) begin
               // chain requests on arbitrary blocks
               case ($urandom_range(0, 2))
                  0: plan_request(REQ_FREE, IDX_W'($urandom), POS_W'($urandom),
                                  ENT_W'($urandom), got);
                  1: plan_request(REQ_EXTEND, IDX_W'($urandom), POS_W'($urandom),
                                  ENT_W'($urandom), got);
                  default: plan_request(REQ_LOCATE, IDX_W'($urandom), POS_W'($urandom),
                                        ENT_W'($urandom), got);
               endcase
            end else begin
               plan_request(($urandom_range(0, 1) == 0) ? REQ_SPARE_A : REQ_SPARE_B,
                            IDX_W'($urandom), POS_W'($urandom), ENT_W'($urandom), got);
               made--;
            end
            made++;
         end
      end

      // grow one file into a long chain, then walk it and drop it
      plan_request(REQ_ALLOC, IDX_W'($urandom), POS_W'($urandom), ENT_W'($urandom), got);
      if (got.st == ST_OK) begin
         head = got.blk[IDX_W-1:0];
         tail = head;
         k    = 0;
         do begin
            plan_request(REQ_EXTEND, tail, POS_W'($urandom), ENT_W'($urandom), got);
            if (got.st == ST_OK)
               tail = got.blk[IDX_W-1:0];
            k++;
         end while (got.st == ST_OK && k < GROW_BLOCKS);
         plan_request(REQ_ALLOC,  '0,   '0,        '0, got);
         plan_request(REQ_LOCATE, head, 20'hFFFFF, '0, got);
         plan_request(REQ_LOCATE, head, {STEP_W'(150), OFF_W'($urandom)}, '0, got);
         plan_request(REQ_FREE,   head, '0,        '0, got);
         plan_request(REQ_ALLOC,  '0,   '0,        '0, got);
         plan_request(REQ_EXTEND, tail, '0,        '0, got);
      end

      // release reset, then wait for every result and a quiet tail
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (req_taken < planned_total || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d requests: %0d allocate, %0d free, %0d extend, %0d locate, %0d write,",
               req_taken, kind_count[REQ_ALLOC], kind_count[REQ_FREE],
               kind_count[REQ_EXTEND], kind_count[REQ_LOCATE], kind_count[REQ_WRITE]);
      $display("%0d read, %0d undefined; results %0d ok, %0d table full, %0d broken; %0d faults",
               kind_count[REQ_READ], kind_count[REQ_SPARE_A] + kind_count[REQ_SPARE_B],
               stat_count[ST_OK], stat_count[ST_NO_FREE], stat_count[ST_BROKEN], fault_count);
      if (fault_count == 0 && expected_rsp.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // stop a hung run
   initial begin
      #(RUN_LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule
